>>> src/sliding_window_median_outlier_flag_top_macros.svh
// Assertion macros for the sliding-window median outlier flag.
`ifndef SLIDING_WINDOW_MEDIAN_OUTLIER_FLAG_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_OUTLIER_FLAG_TOP_MACROS_SVH

// Same-cycle implication, clocked by clk_i, off while rst_ni is low.
`define SWMO_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked by clk_i, off while rst_ni is low.
`define SWMO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/swmo_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window median outlier flag.
package swmo_pkg;

  localparam int AMOUNT_W       = 8;
  localparam int LEN_CFG_W      = 11;
  localparam int TALLY_W        = 32;
  localparam int VALUE_BINS_DEF = 256;
  localparam int WINDOW_MAX_DEF = 1024;

  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic               notify;
    logic               window_full;
    logic [TALLY_W-1:0] notify_total;
  } out_item_t;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] window_length;
  } cfg_item_t;

  typedef struct packed {
    logic cfg_wr;
    logic clr_wr;
    logic take;
    logic scan_rd;
    logic dec_rd;
    logic dec_wr;
    logic inc_rd;
    logic inc_wr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic full;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

>>> src/swmo_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interface carrying one payload per transfer.
interface swmo_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/swmo_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module swmo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> src/swmo_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clearing, median scan and histogram update.
module swmo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  swmo_pkg::status_t status_i,
  output swmo_pkg::cmd_t    cmd_o
);
  import swmo_pkg::*;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_DEC_RD = 8'b0000_1000,
    ST_DEC_WR = 8'b0001_0000,
    ST_INC_RD = 8'b0010_0000,
    ST_INC_WR = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   cfg_xfer;
  logic   in_xfer;

  // length writes only between items
  assign cfg_ready_o = (state_q == ST_IDLE) || (state_q == ST_CLEAR);
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_o.take = 1'b1;
          state_d    = status_i.full ? ST_SCAN : ST_INC_RD;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.scan_done) begin
          state_d = ST_DEC_RD;
        end
      end
      ST_DEC_RD: begin
        cmd_o.dec_rd = 1'b1;
        state_d      = ST_DEC_WR;
      end
      ST_DEC_WR: begin
        cmd_o.dec_wr = 1'b1;
        state_d      = ST_INC_RD;
      end
      ST_INC_RD: begin
        cmd_o.inc_rd = 1'b1;
        state_d      = ST_INC_WR;
      end
      ST_INC_WR: begin
        cmd_o.inc_wr = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    // a length write restarts the window
    if (cfg_xfer) begin
      cmd_o        = '0;
      cmd_o.cfg_wr = 1'b1;
      state_d      = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> src/swmo_dp.sv
`timescale 1ns / 1ps
// Datapath: histogram and ring memories, median scan, counters, output register.
`include "sliding_window_median_outlier_flag_top_macros.svh"
module swmo_dp #(
  parameter int VALUE_BINS = swmo_pkg::VALUE_BINS_DEF,
  parameter int WINDOW_MAX = swmo_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  swmo_pkg::cmd_t                   cmd_i,
  output swmo_pkg::status_t                status_o,
  input  logic [swmo_pkg::AMOUNT_W-1:0]    amount_i,
  input  logic [swmo_pkg::LEN_CFG_W-1:0]   cfg_len_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output swmo_pkg::out_item_t              out_item_o
);
  import swmo_pkg::*;

  localparam int BIN_W  = $clog2(VALUE_BINS);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
  localparam int RING_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CNT_W-1:0]    len_q, fill_q, len_new, len_half;
  logic [CNT_W:0]      k_hi, k_lo, cum_q, cum_nxt;
  logic [RING_W-1:0]   ptr_q, ptr_nxt;
  logic [TALLY_W-1:0]  tally_q, tally_nxt;
  logic [AMOUNT_W-1:0] amount_q;
  logic                full_item_q, full, notify;
  logic [BIN_W-1:0]    clr_q, scan_addr_q, data_addr_q, lo_q, hi_q, nb, ob;
  logic                pend_q, lo_found_q, scan_hit;
  logic                out_valid_q;
  out_item_t           out_item_q;

  logic                bin_we, bin_re;
  logic [BIN_W-1:0]    bin_waddr, bin_raddr;
  logic [CNT_W-1:0]    bin_wdata, bin_rdata;
  logic                ring_we, ring_re;
  logic [RING_W-1:0]   ring_waddr, ring_raddr;
  logic [AMOUNT_W-1:0] ring_wdata, ring_rdata;

  // effective window length: zero acts as one, clamp at the ring depth
  always_comb begin
    if (cfg_len_i == '0) begin
      len_new = CNT_W'(1);
    end else if (32'(cfg_len_i) > 32'(WINDOW_MAX)) begin
      len_new = CNT_W'(WINDOW_MAX);
    end else begin
      len_new = CNT_W'(cfg_len_i);
    end
  end

  // ranks of the two middle values (equal for an odd window)
  assign len_half = len_q >> 1;
  assign k_hi     = {1'b0, len_half} + (CNT_W + 1)'(1);
  assign k_lo     = len_q[0] ? k_hi : {1'b0, len_half};

  always_comb begin
    if (32'(amount_q) >= 32'(VALUE_BINS)) begin
      nb = BIN_W'(VALUE_BINS - 1);
    end else begin
      nb = BIN_W'(amount_q);
    end
    if (32'(ring_rdata) >= 32'(VALUE_BINS)) begin
      ob = BIN_W'(VALUE_BINS - 1);
    end else begin
      ob = BIN_W'(ring_rdata);
    end
  end

  assign full     = fill_q >= len_q;
  assign cum_nxt  = cum_q + {1'b0, bin_rdata};
  assign scan_hit = cmd_i.scan_rd && pend_q && (cum_nxt >= k_hi);
  assign notify   = full_item_q && (32'(amount_q) >= (32'(lo_q) + 32'(hi_q)));
  assign ptr_nxt  = ((CNT_W'(ptr_q) + CNT_W'(1)) == len_q) ? '0 : ptr_q + RING_W'(1);
  assign tally_nxt = (notify && (tally_q != '1)) ? tally_q + TALLY_W'(1) : tally_q;

  // histogram port selection
  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = clr_q;
    bin_wdata = '0;
    if (cmd_i.clr_wr) begin
      bin_we = 1'b1;
    end else if (cmd_i.dec_wr) begin
      bin_we    = 1'b1;
      bin_waddr = ob;
      bin_wdata = bin_rdata - CNT_W'(bin_rdata != '0);
    end else if (cmd_i.inc_wr) begin
      bin_we    = 1'b1;
      bin_waddr = nb;
      bin_wdata = bin_rdata + CNT_W'(1);
    end
    bin_re = cmd_i.scan_rd || cmd_i.dec_rd || cmd_i.inc_rd;
    if (cmd_i.scan_rd) begin
      bin_raddr = scan_addr_q;
    end else if (cmd_i.dec_rd) begin
      bin_raddr = ob;
    end else begin
      bin_raddr = nb;
    end
  end

  assign ring_we    = cmd_i.dec_wr || (cmd_i.inc_rd && !full_item_q);
  assign ring_waddr = cmd_i.dec_wr ? ptr_q : fill_q[RING_W-1:0];
  assign ring_wdata = amount_q;
  assign ring_re    = cmd_i.take;
  assign ring_raddr = ptr_q;

  swmo_ram #(.WIDTH(CNT_W), .DEPTH(VALUE_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (bin_re),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  swmo_ram #(.WIDTH(AMOUNT_W), .DEPTH(WINDOW_MAX)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= CNT_W'(1);
      fill_q      <= '0;
      ptr_q       <= '0;
      tally_q     <= '0;
      clr_q       <= '0;
      full_item_q <= 1'b0;
      scan_addr_q <= '0;
      pend_q      <= 1'b0;
      lo_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_wr) begin
        len_q  <= len_new;
        fill_q <= '0;
        ptr_q  <= '0;
        clr_q  <= '0;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + BIN_W'(1);
      end
      if (cmd_i.take) begin
        full_item_q <= full;
        scan_addr_q <= '0;
        pend_q      <= 1'b0;
        lo_found_q  <= 1'b0;
      end
      if (cmd_i.scan_rd) begin
        scan_addr_q <= scan_addr_q + BIN_W'(1);
        pend_q      <= 1'b1;
        if (pend_q && (cum_nxt >= k_lo)) begin
          lo_found_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        tally_q     <= tally_nxt;
        out_valid_q <= 1'b1;
        if (full_item_q) begin
          ptr_q <= ptr_nxt;
        end else begin
          fill_q <= fill_q + CNT_W'(1);
          ptr_q  <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      amount_q <= amount_i;
      cum_q    <= '0;
    end
    if (cmd_i.scan_rd) begin
      data_addr_q <= scan_addr_q;
    end
    if (cmd_i.scan_rd && pend_q) begin
      cum_q <= cum_nxt;
      if (!lo_found_q && (cum_nxt >= k_lo)) begin
        lo_q <= data_addr_q;
      end
      if (cum_nxt >= k_hi) begin
        hi_q <= data_addr_q;
      end
    end
    if (cmd_i.emit) begin
      out_item_q.notify       <= notify;
      out_item_q.window_full  <= full_item_q;
      out_item_q.notify_total <= tally_nxt;
    end
  end

  assign status_o.clr_last  = 32'(clr_q) == 32'(VALUE_BINS - 1);
  assign status_o.full      = full;
  assign status_o.scan_done = scan_hit;
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_item_q;

  `SWMO_ASSERT(a_fill_le_len, 1'b1, fill_q <= len_q, "fill level beyond window length")
  `SWMO_ASSERT(a_ptr_in_window, 1'b1, CNT_W'(ptr_q) < len_q, "oldest pointer outside window")
  `SWMO_ASSERT(a_hit_has_lo, scan_hit, lo_found_q || (cum_nxt >= k_lo), "upper median before lower")
  `SWMO_ASSERT(a_one_bin_write, 1'b1, $onehot0({cmd_i.clr_wr, cmd_i.dec_wr, cmd_i.inc_wr}), "histogram write conflict")
  `SWMO_ASSERT_NEXT(a_full_keeps_fill, cmd_i.emit && full_item_q, $stable(fill_q), "fill moved on full window")
endmodule

>>> src/sliding_window_median_outlier_flag_top.sv
`timescale 1ns / 1ps
// Top level of the sliding-window median outlier flag.
// Filling window: the new bin is incremented and the result emitted before the next transfer.
// Full window: the median scan reads one histogram bin per cycle until it finds the upper median bin;
//   then the old bin is decremented, the new bin incremented and the result emitted.
// After reset and after every window_length write a clearing pass zeroes the histogram,
//   with no input transfer taken; reset sets window_length to 1 and the tally to 0.
module sliding_window_median_outlier_flag_top #(
  parameter int VALUE_BINS = swmo_pkg::VALUE_BINS_DEF,
  parameter int WINDOW_MAX = swmo_pkg::WINDOW_MAX_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  swmo_if.sink   amount_in,
  swmo_if.source result_out,
  swmo_if.sink   cfg_in
);
  import swmo_pkg::*;

  cmd_t    cmd;
  status_t status;

  swmo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (amount_in.valid),
    .in_ready_o  (amount_in.ready),
    .cfg_valid_i (cfg_in.valid),
    .cfg_ready_o (cfg_in.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  swmo_dp #(
    .VALUE_BINS (VALUE_BINS),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .amount_i    (amount_in.data.amount),
    .cfg_len_i   (cfg_in.data.window_length),
    .out_ready_i (result_out.ready),
    .out_valid_o (result_out.valid),
    .out_item_o  (result_out.data)
  );
endmodule
